[hdl/arl_pkg.sv]
// Shared constants, codes and types of the admissible rank locator.
package arl_pkg;

   localparam int unsigned WORD_W        = 64;
   localparam int unsigned DIGIT_W       = 3;
   localparam int unsigned MAX_DIGITS    = 64;
   localparam int unsigned COUNT_W       = $clog2(MAX_DIGITS + 1);
   localparam int unsigned DIV_CNT_W     = $clog2(WORD_W + 1);
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned SPLIT_BITS    = 4;
   localparam int unsigned SPLIT_STEPS   = WORD_W / SPLIT_BITS;
   localparam int unsigned SPLIT_CNT_W   = $clog2(SPLIT_STEPS + 1);
   localparam logic [DIGIT_W-1:0] MIN_BASE = DIGIT_W'(2);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIGIT_BASE   = 2'd0,
      CSR_START_OFFSET = 2'd1,
      CSR_BLOCK_SIZE   = 2'd2,
      CSR_LIMIT_Q      = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_LAUNCH,
      ST_SPLIT,
      ST_MUL,
      ST_ACC,
      ST_FINAL,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] t_digit;
      logic [DIGIT_W-1:0] q_digit;
      logic [WORD_W-1:0]  t_quot;
      logic [WORD_W-1:0]  q_quot;
   } split_result_type;

endpackage

[hdl/arl_serial_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module arl_serial_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [arl_pkg::WORD_W-1:0]  dividend,
   input  logic [arl_pkg::WORD_W-1:0]  divisor,
   output logic                        done,
   output logic [arl_pkg::WORD_W-1:0]  quotient
);
   import arl_pkg::*;

   logic [WORD_W-1:0]    quot_ff, quot_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WORD_W:0]      rem_shift;
   logic [WORD_W:0]      rem_diff;
   logic                 fits;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[WORD_W-1]};
      fits      = rem_shift >= {1'b0, divisor};
      rem_diff  = rem_shift - {1'b0, divisor};
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(WORD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in  = rem_diff[WORD_W-1:0];
            quot_in = {quot_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[WORD_W-1:0];
            quot_in = {quot_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

[hdl/arl_radix_split.sv]
// Splits the low base-p digit off two words at once, four bits per cycle.
module arl_radix_split (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [arl_pkg::DIGIT_W-1:0]   base,
   input  logic [arl_pkg::WORD_W-1:0]    t_value,
   input  logic [arl_pkg::WORD_W-1:0]    q_value,
   output logic                          done,
   output arl_pkg::split_result_type     result
);
   import arl_pkg::*;

   logic [WORD_W-1:0]      tq_ff, tq_in;
   logic [WORD_W-1:0]      qq_ff, qq_in;
   logic [DIGIT_W-1:0]     trem_ff, trem_in;
   logic [DIGIT_W-1:0]     qrem_ff, qrem_in;
   logic [SPLIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIGIT_W+SPLIT_BITS-1:0] t_step;
   logic [DIGIT_W+SPLIT_BITS-1:0] q_step;

   // Long division of a few bits by the base; the remainder stays below the base.
   function automatic logic [DIGIT_W+SPLIT_BITS-1:0] radix_step(
      input logic [DIGIT_W-1:0]    rem,
      input logic [SPLIT_BITS-1:0] bits,
      input logic [DIGIT_W-1:0]    div
   );
      logic [DIGIT_W:0]      r;
      logic [SPLIT_BITS-1:0] qb;
      r  = {1'b0, rem};
      qb = '0;
      for (int k = SPLIT_BITS - 1; k >= 0; k--) begin
         r = {r[DIGIT_W-1:0], bits[k]};
         if (r >= {1'b0, div}) begin
            r     = r - {1'b0, div};
            qb[k] = 1'b1;
         end
      end
      return {r[DIGIT_W-1:0], qb};
   endfunction

   always_comb begin
      t_step  = radix_step(trem_ff, tq_ff[WORD_W-1 -: SPLIT_BITS], base);
      q_step  = radix_step(qrem_ff, qq_ff[WORD_W-1 -: SPLIT_BITS], base);
      tq_in   = tq_ff;
      qq_in   = qq_ff;
      trem_in = trem_ff;
      qrem_in = qrem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         tq_in   = t_value;
         qq_in   = q_value;
         trem_in = '0;
         qrem_in = '0;
         cnt_in  = SPLIT_CNT_W'(SPLIT_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         tq_in   = {tq_ff[WORD_W-SPLIT_BITS-1:0], t_step[SPLIT_BITS-1:0]};
         qq_in   = {qq_ff[WORD_W-SPLIT_BITS-1:0], q_step[SPLIT_BITS-1:0]};
         trem_in = t_step[DIGIT_W+SPLIT_BITS-1:SPLIT_BITS];
         qrem_in = q_step[DIGIT_W+SPLIT_BITS-1:SPLIT_BITS];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == SPLIT_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      tq_ff   <= tq_in;
      qq_ff   <= qq_in;
      trem_ff <= trem_in;
      qrem_ff <= qrem_in;
   end

   assign done           = done_ff;
   assign result.t_digit = trem_ff;
   assign result.q_digit = qrem_ff;
   assign result.t_quot  = tq_ff;
   assign result.q_quot  = qq_ff;

endmodule

[hdl/admissible_rank_locator.sv]
// Top level of the admissible rank locator: control, accumulators and ports.
//
//   channel   handshake                 payload
//   input     start / busy              req_query_value
//   result    rsp_valid (strobe)        rsp_hit, rsp_rank, rsp_admissible_j,
//                                       rsp_interval_index, rsp_violation_digit
//   config    csr_write_enable          csr_index, csr_write_data
//
// A word is taken at a clock edge where start is high and busy is low. The block
// then works on that word alone and holds busy high until its result is shown.
// The serial divider works out t = (n - offset) / block, then t is compared with
// q, and then every base-p digit of q passes through the digit splitter and the
// accumulators in turn; q has at most 64 such digits, in base two. A query below
// the offset goes straight to the result state without the divider, and a t not
// below q goes there from the compare.
// Reset is synchronous and active high; it restores the register defaults
// (base 2, offset 0, block size 1, limit 1) and returns the block to idle.
// The result word sits on the rsp_ ports for exactly one cycle with rsp_valid;
// the receiver cannot stall it.
module admissible_rank_locator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [arl_pkg::WORD_W-1:0]       req_query_value,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic [arl_pkg::WORD_W-1:0]       rsp_rank,
   output logic [arl_pkg::WORD_W-1:0]       rsp_admissible_j,
   output logic [arl_pkg::WORD_W-1:0]       rsp_interval_index,
   output logic [arl_pkg::COUNT_W-1:0]      rsp_violation_digit,
   input  logic                             csr_write_enable,
   input  logic [arl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [arl_pkg::WORD_W-1:0]       csr_write_data
);
   import arl_pkg::*;

   // Configuration registers.
   logic [DIGIT_W-1:0] base_ff;
   logic [WORD_W-1:0]  offset_ff;
   logic [WORD_W-1:0]  block_ff;
   logic [WORD_W-1:0]  limq_ff;
   logic [DIGIT_W-1:0] base_eff;

   state_type          state_ff, state_in;

   // Digit loop registers.
   logic [WORD_W-1:0]  interval_ff, interval_in;
   logic [WORD_W-1:0]  t_work_ff, t_work_in;
   logic [WORD_W-1:0]  q_work_ff, q_work_in;
   logic [WORD_W-1:0]  place_ff, place_in;
   logic [WORD_W-1:0]  weight_ff, weight_in;
   logic [WORD_W-1:0]  jacc_ff, jacc_in;
   logic [WORD_W-1:0]  racc_ff, racc_in;
   logic [WORD_W-1:0]  qlowj_ff, qlowj_in;
   logic [WORD_W-1:0]  qlowr_ff, qlowr_in;
   logic [WORD_W-1:0]  prod_tj_ff, prod_tj_in;
   logic [WORD_W-1:0]  prod_tr_ff, prod_tr_in;
   logic [WORD_W-1:0]  prod_qj_ff, prod_qj_in;
   logic [WORD_W-1:0]  prod_qr_ff, prod_qr_in;
   logic [WORD_W-1:0]  place_nx_ff, place_nx_in;
   logic [WORD_W-1:0]  weight_nx_ff, weight_nx_in;
   logic [COUNT_W-1:0] digit_ff, digit_in;
   logic [COUNT_W-1:0] viol_pos_ff, viol_pos_in;
   logic               viol_ff, viol_in;

   // Result registers.
   logic               res_hit_ff, res_hit_in;
   logic [WORD_W-1:0]  res_rank_ff, res_rank_in;
   logic [WORD_W-1:0]  res_j_ff, res_j_in;
   logic [WORD_W-1:0]  res_t_ff, res_t_in;
   logic [COUNT_W-1:0] res_viol_ff, res_viol_in;

   logic               accept;
   logic               below_offset;
   logic [WORD_W-1:0]  relative;
   logic               div_start, div_done;
   logic [WORD_W-1:0]  div_quot;
   logic               split_start, split_done;
   split_result_type   split_res;
   logic               digit_viol;
   logic [WORD_W-1:0]  qlowj_sum, qlowr_sum;

   // A base below two is treated as two.
   assign base_eff     = (base_ff < MIN_BASE) ? MIN_BASE : base_ff;
   assign accept       = start && !busy;
   assign below_offset = req_query_value < offset_ff;
   assign relative     = req_query_value - offset_ff;

   arl_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (relative),
      .divisor  (block_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   arl_radix_split u_split (
      .clock   (clock),
      .reset   (reset),
      .start   (split_start),
      .base    (base_eff),
      .t_value (t_work_ff),
      .q_value (q_work_ff),
      .done    (split_done),
      .result  (split_res)
   );

   // Configuration writes; the low three bits of a write set the base.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= MIN_BASE;
         offset_ff <= '0;
         block_ff  <= WORD_W'(1);
         limq_ff   <= WORD_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIGIT_BASE:   base_ff   <= csr_write_data[DIGIT_W-1:0];
            CSR_START_OFFSET: offset_ff <= csr_write_data;
            CSR_BLOCK_SIZE:   block_ff  <= csr_write_data;
            CSR_LIMIT_Q:      limq_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The digits arrive least significant first. A violating digit overrides
   // everything below it, so at a violation j and rank restart from the low
   // part of q, and above it t's digits are added on as usual.
   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      t_work_in    = t_work_ff;
      q_work_in    = q_work_ff;
      place_in     = place_ff;
      weight_in    = weight_ff;
      jacc_in      = jacc_ff;
      racc_in      = racc_ff;
      qlowj_in     = qlowj_ff;
      qlowr_in     = qlowr_ff;
      prod_tj_in   = prod_tj_ff;
      prod_tr_in   = prod_tr_ff;
      prod_qj_in   = prod_qj_ff;
      prod_qr_in   = prod_qr_ff;
      place_nx_in  = place_nx_ff;
      weight_nx_in = weight_nx_ff;
      digit_in     = digit_ff;
      viol_pos_in  = viol_pos_ff;
      viol_in      = viol_ff;
      res_hit_in   = res_hit_ff;
      res_rank_in  = res_rank_ff;
      res_j_in     = res_j_ff;
      res_t_in     = res_t_ff;
      res_viol_in  = res_viol_ff;
      div_start    = 1'b0;
      split_start  = 1'b0;
      digit_viol   = split_res.t_digit > split_res.q_digit;
      qlowj_sum    = qlowj_ff + prod_qj_ff;
      qlowr_sum    = qlowr_ff + prod_qr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (below_offset) begin
                  res_hit_in  = 1'b0;
                  res_rank_in = '0;
                  res_j_in    = '0;
                  res_t_in    = '0;
                  res_viol_in = '0;
                  state_in    = ST_RESPOND;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               interval_in = div_quot;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (interval_ff >= limq_ff) begin
               res_hit_in  = 1'b0;
               res_rank_in = '0;
               res_j_in    = '0;
               res_t_in    = '0;
               res_viol_in = '0;
               state_in    = ST_RESPOND;
            end else begin
               t_work_in   = interval_ff;
               q_work_in   = limq_ff;
               place_in    = WORD_W'(1);
               weight_in   = WORD_W'(1);
               jacc_in     = '0;
               racc_in     = '0;
               qlowj_in    = '0;
               qlowr_in    = '0;
               digit_in    = '0;
               viol_pos_in = '0;
               viol_in     = 1'b0;
               state_in    = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            split_start = 1'b1;
            state_in    = ST_SPLIT;
         end
         ST_SPLIT: begin
            if (split_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_tj_in   = place_ff * WORD_W'(split_res.t_digit);
            prod_tr_in   = weight_ff * WORD_W'(split_res.t_digit);
            prod_qj_in   = place_ff * WORD_W'(split_res.q_digit);
            prod_qr_in   = weight_ff * WORD_W'(split_res.q_digit);
            place_nx_in  = place_ff * WORD_W'(base_eff);
            weight_nx_in = weight_ff * (WORD_W'(split_res.q_digit) + WORD_W'(1));
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            qlowj_in = qlowj_sum;
            qlowr_in = qlowr_sum;
            if (digit_viol) begin
               jacc_in     = qlowj_sum;
               racc_in     = qlowr_sum;
               viol_in     = 1'b1;
               viol_pos_in = digit_ff;
            end else begin
               jacc_in = jacc_ff + prod_tj_ff;
               racc_in = racc_ff + prod_tr_ff;
            end
            place_in  = place_nx_ff;
            weight_in = weight_nx_ff;
            t_work_in = split_res.t_quot;
            q_work_in = split_res.q_quot;
            digit_in  = digit_ff + COUNT_W'(1);
            // Since t is below q, q has the most digits and ends the loop.
            if (split_res.q_quot == '0) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_LAUNCH;
            end
         end
         ST_FINAL: begin
            if (jacc_ff >= limq_ff) begin
               res_hit_in  = 1'b0;
               res_rank_in = '0;
               res_j_in    = '0;
               res_t_in    = '0;
               res_viol_in = '0;
            end else begin
               res_hit_in  = 1'b1;
               res_rank_in = racc_ff;
               res_j_in    = jacc_ff;
               res_t_in    = interval_ff;
               res_viol_in = viol_ff ? viol_pos_ff : digit_ff;
            end
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      interval_ff  <= interval_in;
      t_work_ff    <= t_work_in;
      q_work_ff    <= q_work_in;
      place_ff     <= place_in;
      weight_ff    <= weight_in;
      jacc_ff      <= jacc_in;
      racc_ff      <= racc_in;
      qlowj_ff     <= qlowj_in;
      qlowr_ff     <= qlowr_in;
      prod_tj_ff   <= prod_tj_in;
      prod_tr_ff   <= prod_tr_in;
      prod_qj_ff   <= prod_qj_in;
      prod_qr_ff   <= prod_qr_in;
      place_nx_ff  <= place_nx_in;
      weight_nx_ff <= weight_nx_in;
      digit_ff     <= digit_in;
      viol_pos_ff  <= viol_pos_in;
      viol_ff      <= viol_in;
      res_hit_ff   <= res_hit_in;
      res_rank_ff  <= res_rank_in;
      res_j_ff     <= res_j_in;
      res_t_ff     <= res_t_in;
      res_viol_ff  <= res_viol_in;
   end

   assign busy                = state_ff != ST_IDLE;
   assign rsp_valid           = state_ff == ST_RESPOND;
   assign rsp_hit             = res_hit_ff;
   assign rsp_rank            = res_rank_ff;
   assign rsp_admissible_j    = res_j_ff;
   assign rsp_interval_index  = res_t_ff;
   assign rsp_violation_digit = res_viol_ff;

   // A miss carries nothing but zeros.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_rank == '0) && (rsp_admissible_j == '0) &&
                                (rsp_interval_index == '0) && (rsp_violation_digit == '0))
      else $error("miss result carries nonzero fields");

   // A hit lies below the limit and not above t.
   a_hit_below_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_admissible_j < limq_ff)
      else $error("hit with j not below the limit");

   a_j_not_above_t: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_admissible_j <= rsp_interval_index)
      else $error("j above the interval index");

   // Exactly one result word per accepted word.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

endmodule

[sim/tb_admissible_rank_locator.sv]
// Self-checking testbench of the admissible rank locator.
`timescale 1ns / 1ps

module tb_admissible_rank_locator;
   import arl_pkg::*;

   // One result word as the block shows it on the rsp_ ports.
   typedef struct packed {
      bit                hit;
      bit [WORD_W-1:0]   rank;
      bit [WORD_W-1:0]   admissible_j;
      bit [WORD_W-1:0]   interval_index;
      bit [COUNT_W-1:0]  violation_digit;
   } locate_word_type;

   typedef bit [WORD_W-1:0] digit_array_type [MAX_DIGITS];

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [WORD_W-1:0]       req_query_value = '0;
   logic                    rsp_valid;
   logic                    rsp_hit;
   logic [WORD_W-1:0]       rsp_rank;
   logic [WORD_W-1:0]       rsp_admissible_j;
   logic [WORD_W-1:0]       rsp_interval_index;
   logic [COUNT_W-1:0]      rsp_violation_digit;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [WORD_W-1:0]       csr_write_data = '0;

   // Our own copy of the configuration registers, updated with every write.
   bit [DIGIT_W-1:0]  base_reg   = 3'd2;
   bit [WORD_W-1:0]   offset_reg = '0;
   bit [WORD_W-1:0]   block_reg  = 64'd1;
   bit [WORD_W-1:0]   limit_reg  = 64'd1;

   bit [WORD_W-1:0]  query_queue [$];
   locate_word_type  locate_queue [$];
   bit               word_taken = 1'b0;
   bit               idling_on  = 1'b1;
   int               gap_left   = 0;
   int               error_count = 0;

   admissible_rank_locator u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_query_value     (req_query_value),
      .rsp_valid           (rsp_valid),
      .rsp_hit             (rsp_hit),
      .rsp_rank            (rsp_rank),
      .rsp_admissible_j    (rsp_admissible_j),
      .rsp_interval_index  (rsp_interval_index),
      .rsp_violation_digit (rsp_violation_digit),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run ends here if the block hangs. The slowest correct run, about 1350
   // words each at the longest query time, takes some 18 ms; this is four times that.
   initial begin
      #80ms;
      $display("[admissible_rank_locator] ERROR");
      $finish;
   end

   // Writes v in base b, least significant digit first, and returns the digit
   // count, which is at least one even for zero.
   function automatic int split_digits(input bit [WORD_W-1:0] v, input bit [WORD_W-1:0] b,
                                       output digit_array_type dig);
      int cnt;
      cnt = 0;
      for (int i = 0; i < MAX_DIGITS; i++) dig[i] = '0;
      if (v == 0) return 1;
      while (v > 0 && cnt < MAX_DIGITS) begin
         dig[cnt] = v % b;
         v = v / b;
         cnt++;
      end
      return cnt;
   endfunction

   // Computes the expected result word for query n under the current registers.
   function automatic locate_word_type locate_query(input bit [WORD_W-1:0] n);
      locate_word_type res;
      digit_array_type t_dig, q_dig;
      bit [WORD_W-1:0] b, t, j, rank_acc, place, weight, d;
      int tn, qn, width, h;
      bit viol;
      res = '0;
      j = 0; rank_acc = 0; place = 1; weight = 1; h = 0; viol = 0;
      if (n < offset_reg) return res;
      t = (block_reg == 0) ? '1 : (n - offset_reg) / block_reg;
      if (t >= limit_reg) return res;
      // A base of zero or one behaves as base two.
      b = (base_reg < 2) ? 64'd2 : WORD_W'(base_reg);
      tn = split_digits(t, b, t_dig);
      qn = split_digits(limit_reg, b, q_dig);
      width = (tn > qn) ? tn : qn;
      // The most significant digit where t exceeds q decides the split point.
      for (int r = width; r > 0; r--) begin
         if (!viol && t_dig[r-1] > q_dig[r-1]) begin
            viol = 1;
            h = r - 1;
         end
      end
      // Above the split j keeps t's digits, at and below it takes q's.
      for (int r = 0; r < width; r++) begin
         d = (!viol || r > h) ? t_dig[r] : q_dig[r];
         j += d * place;
         rank_acc += d * weight;
         place *= b;
         weight *= q_dig[r] + 1;
      end
      if (j >= limit_reg) return res;
      res.hit             = 1'b1;
      res.rank            = rank_acc;
      res.admissible_j    = j;
      res.interval_index  = t;
      res.violation_digit = COUNT_W'(viol ? h : width);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input bit [WORD_W-1:0] got,
                                  input bit [WORD_W-1:0] want);
      $display("%0t mismatch on %s: got 0x%h, expected 0x%h", $realtime, what, got, want);
      error_count++;
   endtask

   // A word is accepted here; its expected result is worked out at once, since
   // the bench writes the registers only after the block has answered every word.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         locate_queue.push_back(locate_query(req_query_value));
         word_taken = 1'b1;
      end
   end

   // Result checker: every strobe is matched against the oldest expectation.
   always @(posedge clock) begin
      locate_word_type want;
      if (!reset && rsp_valid) begin
         if (locate_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_admissible_j, '0);
         end else begin
            want = locate_queue.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch("hit", WORD_W'(rsp_hit), WORD_W'(want.hit));
            if (rsp_rank !== want.rank) report_mismatch("rank", rsp_rank, want.rank);
            if (rsp_admissible_j !== want.admissible_j)
               report_mismatch("admissible_j", rsp_admissible_j, want.admissible_j);
            if (rsp_interval_index !== want.interval_index)
               report_mismatch("interval_index", rsp_interval_index, want.interval_index);
            if (rsp_violation_digit !== want.violation_digit)
               report_mismatch("violation_digit", WORD_W'(rsp_violation_digit),
                               WORD_W'(want.violation_digit));
         end
      end
   end

   // Driver: start is held with the same word until the block takes it; only
   // between words does it drop, for a random idle burst or for lack of work.
   always @(negedge clock) begin
      bit free;
      free = !start || word_taken;
      if (word_taken) begin
         void'(query_queue.pop_front());
         word_taken = 1'b0;
      end
      if (!reset && free) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (idling_on && query_queue.size() > 0 && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 13) - 1;
            start <= 1'b0;
         end else if (query_queue.size() > 0) begin
            start <= 1'b1;
            req_query_value <= query_queue[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic bit [WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Waits until every queued word has been taken and answered, then lets the
   // block settle before any register changes.
   task automatic drain_block();
      wait (query_queue.size() == 0 && locate_queue.size() == 0 && !start);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input bit [WORD_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         CSR_DIGIT_BASE:   base_reg   = value[DIGIT_W-1:0];
         CSR_START_OFFSET: offset_reg = value;
         CSR_BLOCK_SIZE:   block_reg  = value;
         CSR_LIMIT_Q:      limit_reg  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_setting(input bit [WORD_W-1:0] b, input bit [WORD_W-1:0] off,
                               input bit [WORD_W-1:0] blk, input bit [WORD_W-1:0] lim);
      drain_block();
      write_register(CSR_DIGIT_BASE, b);
      write_register(CSR_START_OFFSET, off);
      write_register(CSR_BLOCK_SIZE, blk);
      write_register(CSR_LIMIT_Q, lim);
   endtask

   // Mostly well-formed queries that land near or below the limit, plus noise
   // and queries under the offset.
   function automatic bit [WORD_W-1:0] make_query();
      bit [WORD_W-1:0] t, rem;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return rand64();
      if (pick == 1 && offset_reg > 0) return rand64() % offset_reg;
      t = rand64() % (limit_reg + (limit_reg >> 2) + 2);
      rem = (block_reg == 0) ? '0 : rand64() % block_reg;
      return offset_reg + t * block_reg + rem;
   endfunction

   initial begin
      bit [WORD_W-1:0] b, off, blk, lim;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: reset defaults, then extremes and the corner settings.
      query_queue.push_back('0);
      query_queue.push_back(64'd1);
      query_queue.push_back('1);
      load_setting(64'd2, '0, 64'd1, '1);
      query_queue.push_back('0);
      query_queue.push_back('1);
      query_queue.push_back(64'hFFFF_FFFF_FFFF_FFFE);
      query_queue.push_back(64'h5555_5555_5555_5555);
      query_queue.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      // Base below two, a zero block size and a zero limit.
      load_setting(64'hFFFF_FFFF_FFFF_FFF8, 64'd10, 64'd3, 64'd100);
      query_queue.push_back(64'd9);
      query_queue.push_back(64'd10);
      query_queue.push_back(64'd250);
      query_queue.push_back(64'd400);
      load_setting(64'd1, '1, '0, 64'd50);
      query_queue.push_back('1);
      query_queue.push_back(64'd7);
      load_setting(64'd7, '0, 64'd1, '0);
      query_queue.push_back('0);
      query_queue.push_back(64'd1234);
      // Large base and a limit with many digits.
      load_setting(64'd7, 64'd5, 64'd49, '1);
      query_queue.push_back(64'd5);
      query_queue.push_back('1);
      query_queue.push_back(64'd4);
      load_setting(64'd3, '0, 64'd1, 64'd200);
      for (int i = 0; i < 6; i++) query_queue.push_back(64'(i * 37 + 1));

      // Random part. Every phase is a new setting written into an idle block,
      // which also holds the sender off until all results are in.
      for (int phase = 0; phase < 40; phase++) begin
         if (phase == 36) idling_on = 1'b0;
         b = {rand64() & ~64'h7} | 64'($urandom_range(0, 7));
         case ($urandom_range(0, 3))
            0: off = '0;
            1: off = 64'($urandom_range(0, 1000));
            2: off = rand64();
            default: off = (phase % 8 == 0) ? '1 : rand64() >> $urandom_range(1, 63);
         endcase
         case ($urandom_range(0, 9))
            0: blk = '0;
            1, 2: blk = 64'd1;
            3, 4, 5: blk = 64'($urandom_range(2, 300));
            6: blk = '1;
            default: blk = rand64() >> $urandom_range(0, 63);
         endcase
         case ($urandom_range(0, 11))
            0: lim = '0;
            1: lim = rand64();
            2: lim = '1;
            default: lim = 64'($urandom_range(1, 4000));
         endcase
         load_setting(b, off, blk, lim);
         for (int i = 0; i < 33; i++) query_queue.push_back(make_query());
      end

      drain_block();
      if (error_count == 0) begin
         $display("[admissible_rank_locator] OK");
      end else begin
         $display("[admissible_rank_locator] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/arl_pkg.sv
hdl/arl_serial_div.sv
hdl/arl_radix_split.sv
hdl/admissible_rank_locator.sv
sim/tb_admissible_rank_locator.sv
